### sv/lmct_pkg.sv
// Shared types and codes of the method cache tag manager.
// No dependencies; used by lmct_cell and lru_method_cache_tags.
package lmct_pkg;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] method_address;
      logic [31:0] size_word;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] active_slot;
      logic [4:0] evicted_by_capacity;
      logic [4:0] evicted_by_tag;
      logic [4:0] released_blocks;
      logic [4:0] resident_methods;
      logic [4:0] resident_blocks;
   } rsp_type;

   typedef struct packed {
      logic take_upper;
      logic load_new;
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEARCH, ST_DECIDE, ST_EVICT, ST_INSERT, ST_MOVE, ST_REPLY
   } state_type;

   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_START  = 2'd1;
   localparam logic [1:0] KIND_FLUSH  = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [2:0] STATUS_HIT      = 3'd0;
   localparam logic [2:0] STATUS_MISS     = 3'd1;
   localparam logic [2:0] STATUS_RELOAD   = 3'd2;
   localparam logic [2:0] STATUS_SIZE_ERR = 3'd3;
   localparam logic [2:0] STATUS_DONE     = 3'd4;

   localparam logic CSR_MAX_METHODS = 1'b0;
   localparam logic CSR_BLOCK_LOG2  = 1'b1;

   localparam logic [31:0] DISP_FLAG = 32'h0001_0000;

endpackage

### sv/lru_method_cache_tags.sv
// Top level of the LRU method cache tag manager: sequencer, counters, row of slot cells.
// Depends on lmct_pkg and lmct_cell.
//
//  channel | ports                          | transfer
//  request | start, busy, req_data          | start high while busy low
//  result  | rsp_strobe, rsp_data           | every cycle rsp_strobe is high
//  config  | csr_we, csr_index, csr_wdata   | every cycle csr_we is high
//
// A request goes from its accepting edge through SEARCH, DECIDE, REPLY (size error,
// flush, unused kind), SEARCH, DECIDE, MOVE, REPLY with a table move (hit, reload,
// start), and for a miss SEARCH, DECIDE, EVICT, INSERT, MOVE, REPLY, EVICT taking
// one entry per cycle. busy is high until the result cycle ends; the next transfer follows.
// Reset empties the table at once; slot contents need no clearing.
// The result is shown for one cycle; the receiver cannot stall it.
module lru_method_cache_tags #(
   parameter int NUM_ENTRIES = 16,
   parameter int ADDR_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lmct_pkg::req_type req_data,
   output logic              rsp_strobe,
   output lmct_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [4:0]        csr_wdata
);

   localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int CW = $clog2(NUM_ENTRIES + 1);
   localparam int XW = ((CW > 5) ? CW : 5) + 1;
   localparam logic [IW-1:0] HEAD = IW'(NUM_ENTRIES - 1);
   localparam logic [XW-1:0] NX = XW'(NUM_ENTRIES);

   lmct_pkg::state_type state_ff, state_in;

   logic [1:0]            kind_ff, kind_in;
   logic [ADDR_WIDTH-1:0] addr_ff, addr_in;
   logic                  flag_ff, flag_in;
   logic [CW-1:0]         nb_ff, nb_in;
   logic                  bad_ff, bad_in;
   logic [NUM_ENTRIES-1:0] match_ff, match_in;
   logic [CW-1:0]         mc_ff, mc_in, bc_ff, bc_in, dc_ff, dc_in;
   logic [IW-1:0]         active_ff, active_in;
   logic [2:0]            status_ff, status_in;
   logic [CW-1:0]         evc_ff, evc_in, evt_ff, evt_in, evb_ff, evb_in;
   logic [IW-1:0]         from_ff, from_in, to_ff, to_in;
   logic [ADDR_WIDTH-1:0] nbase_ff, nbase_in;
   logic [CW-1:0]         nblk_ff, nblk_in;
   logic                  ndisp_ff, ndisp_in;
   logic [4:0]            maxm_ff, bsl_ff;

   logic [ADDR_WIDTH-1:0] base_arr [NUM_ENTRIES];
   logic [CW-1:0]         blk_arr  [NUM_ENTRIES];
   logic                  disp_arr [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] match_raw;

   logic [31:0]   bytes_c, shifted_c;
   logic [32:0]   nb_full_c;
   logic          found_c;
   logic [IW-1:0] idx_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         maxm_ff <= 5'd16;
         bsl_ff  <= 5'd5;
      end else if (csr_we) begin
         unique case (csr_index)
            lmct_pkg::CSR_MAX_METHODS: maxm_ff <= csr_wdata;
            lmct_pkg::CSR_BLOCK_LOG2:  bsl_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < NUM_ENTRIES; gi++) begin : g_cell
         lmct_pkg::cell_ctrl_type ctrl;
         logic [ADDR_WIDTH-1:0]   ub;
         logic [CW-1:0]           ubl;
         logic                    ud;
         assign ctrl.take_upper = (state_ff == lmct_pkg::ST_MOVE) &&
                                  (IW'(gi) >= from_ff) && (IW'(gi) < to_ff);
         assign ctrl.load_new   = (state_ff == lmct_pkg::ST_MOVE) && (IW'(gi) == to_ff);
         if (gi == NUM_ENTRIES - 1) begin : g_top
            assign ub  = nbase_ff;
            assign ubl = nblk_ff;
            assign ud  = ndisp_ff;
         end else begin : g_mid
            assign ub  = base_arr[gi+1];
            assign ubl = blk_arr[gi+1];
            assign ud  = disp_arr[gi+1];
         end
         lmct_cell #(.ADDR_WIDTH(ADDR_WIDTH), .BW(CW)) u_cell (
            .clock(clock), .ctrl(ctrl),
            .up_base(ub), .up_blocks(ubl), .up_disp(ud),
            .new_base(nbase_ff), .new_blocks(nblk_ff), .new_disp(ndisp_ff),
            .cmp_addr(addr_ff),
            .base(base_arr[gi]), .blocks(blk_arr[gi]), .disp(disp_arr[gi]),
            .match(match_raw[gi])
         );
      end
   endgenerate

   always_comb begin
      found_c = 1'b0;
      idx_c   = '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (match_ff[i]) begin
            found_c = 1'b1;
            idx_c   = IW'(i);
         end
      end
   end

   assign bytes_c   = req_data.size_word & ~lmct_pkg::DISP_FLAG;
   assign shifted_c = (bytes_c - 32'd1) >> bsl_ff;
   assign nb_full_c = (bytes_c == 32'd0) ? 33'd0 : ({1'b0, shifted_c} + 33'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= lmct_pkg::ST_IDLE;
         mc_ff     <= '0;
         bc_ff     <= '0;
         dc_ff     <= '0;
         active_ff <= HEAD;
      end else begin
         state_ff  <= state_in;
         mc_ff     <= mc_in;
         bc_ff     <= bc_in;
         dc_ff     <= dc_in;
         active_ff <= active_in;
      end
      kind_ff  <= kind_in;
      addr_ff  <= addr_in;
      flag_ff  <= flag_in;
      nb_ff    <= nb_in;
      bad_ff   <= bad_in;
      match_ff <= match_in;
      status_ff <= status_in;
      evc_ff   <= evc_in;
      evt_ff   <= evt_in;
      evb_ff   <= evb_in;
      from_ff  <= from_in;
      to_ff    <= to_in;
      nbase_ff <= nbase_in;
      nblk_ff  <= nblk_in;
      ndisp_ff <= ndisp_in;
   end

   always_comb begin
      logic [XW-1:0] nondisp, insw, limit, tailw, mc1, dc1;
      logic [IW-1:0] ins, tail, cur;
      logic          over;
      logic [CW-1:0] eb;
      state_in  = state_ff;
      kind_in   = kind_ff;
      addr_in   = addr_ff;
      flag_in   = flag_ff;
      nb_in     = nb_ff;
      bad_in    = bad_ff;
      match_in  = match_ff;
      mc_in     = mc_ff;
      bc_in     = bc_ff;
      dc_in     = dc_ff;
      active_in = active_ff;
      status_in = status_ff;
      evc_in    = evc_ff;
      evt_in    = evt_ff;
      evb_in    = evb_ff;
      from_in   = from_ff;
      to_in     = to_ff;
      nbase_in  = nbase_ff;
      nblk_in   = nblk_ff;
      ndisp_in  = ndisp_ff;
      nondisp = '0;
      insw    = '0;
      limit   = (maxm_ff == 5'd0) ? XW'(1) : XW'(maxm_ff);
      tailw   = NX - XW'(mc_ff);
      tail    = tailw[IW-1:0];
      eb      = blk_arr[tail];
      over    = (XW'(bc_ff) + XW'(nb_ff)) > NX;
      mc1     = '0;
      dc1     = '0;
      ins     = '0;
      cur     = '0;
      unique case (state_ff)
         lmct_pkg::ST_IDLE: begin
            if (start) begin
               kind_in   = req_data.kind;
               addr_in   = ADDR_WIDTH'(req_data.method_address);
               flag_in   = req_data.size_word[16];
               nb_in     = CW'(nb_full_c);
               bad_in    = (nb_full_c == 33'd0) || (nb_full_c > 33'(NUM_ENTRIES));
               status_in = lmct_pkg::STATUS_DONE;
               evc_in    = '0;
               evt_in    = '0;
               evb_in    = '0;
               state_in  = lmct_pkg::ST_SEARCH;
            end
         end
         lmct_pkg::ST_SEARCH: begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
               match_in[i] = match_raw[i] && ((XW'(i) + XW'(mc_ff)) >= NX);
            end
            state_in = lmct_pkg::ST_DECIDE;
         end
         lmct_pkg::ST_DECIDE: begin
            state_in = lmct_pkg::ST_REPLY;
            priority case (kind_ff)
               lmct_pkg::KIND_LOAD: begin
                  if (found_c && !disp_arr[idx_c]) begin
                     from_in   = idx_c;
                     to_in     = HEAD;
                     nbase_in  = base_arr[idx_c];
                     nblk_in   = blk_arr[idx_c];
                     ndisp_in  = 1'b0;
                     active_in = HEAD;
                     status_in = lmct_pkg::STATUS_HIT;
                     state_in  = lmct_pkg::ST_MOVE;
                  end else if (bad_ff) begin
                     status_in = lmct_pkg::STATUS_SIZE_ERR;
                  end else if (found_c) begin
                     nondisp = XW'(mc_ff) - XW'(dc_ff);
                     insw = (nondisp < NX) ? (NX - XW'(1) - nondisp) : '0;
                     ins  = insw[IW-1:0];
                     if (ins < idx_c) ins = idx_c;
                     from_in   = idx_c;
                     to_in     = ins;
                     nbase_in  = base_arr[idx_c];
                     nblk_in   = blk_arr[idx_c];
                     ndisp_in  = 1'b1;
                     active_in = ins;
                     status_in = lmct_pkg::STATUS_RELOAD;
                     state_in  = lmct_pkg::ST_MOVE;
                  end else begin
                     status_in = lmct_pkg::STATUS_MISS;
                     state_in  = lmct_pkg::ST_EVICT;
                  end
               end
               lmct_pkg::KIND_START: begin
                  if (bad_ff) begin
                     status_in = lmct_pkg::STATUS_SIZE_ERR;
                  end else begin
                     from_in   = HEAD;
                     to_in     = HEAD;
                     nbase_in  = addr_ff;
                     nblk_in   = nb_ff;
                     ndisp_in  = flag_ff;
                     mc_in     = CW'(1);
                     bc_in     = nb_ff;
                     dc_in     = CW'(flag_ff);
                     active_in = HEAD;
                     state_in  = lmct_pkg::ST_MOVE;
                  end
               end
               lmct_pkg::KIND_FLUSH: begin
                  if (mc_ff >= CW'(2)) begin
                     evb_in    = (bc_ff >= blk_arr[HEAD]) ? (bc_ff - blk_arr[HEAD]) : '0;
                     mc_in     = CW'(1);
                     bc_in     = blk_arr[HEAD];
                     dc_in     = CW'(disp_arr[HEAD]);
                     active_in = HEAD;
                  end
               end
               default: ;
            endcase
         end
         lmct_pkg::ST_EVICT: begin
            if (mc_ff != '0 && (over || XW'(mc_ff) >= limit)) begin
               if (over) evc_in = evc_ff + CW'(1);
               else evt_in = evt_ff + CW'(1);
               evb_in = evb_ff + eb;
               bc_in  = (bc_ff >= eb) ? (bc_ff - eb) : '0;
               if (disp_arr[tail] && dc_ff != '0) dc_in = dc_ff - CW'(1);
               mc_in  = mc_ff - CW'(1);
            end else begin
               state_in = lmct_pkg::ST_INSERT;
            end
         end
         lmct_pkg::ST_INSERT: begin
            mc1     = XW'(mc_ff) + XW'(1);
            dc1     = XW'(dc_ff) + XW'(flag_ff);
            nondisp = mc1 - dc1;
            insw    = (flag_ff && nondisp < NX) ? (NX - XW'(1) - nondisp) : (NX - XW'(1));
            tailw   = NX - mc1;
            cur     = tailw[IW-1:0];
            ins     = insw[IW-1:0];
            if (ins < cur) ins = cur;
            mc_in     = CW'(mc1);
            dc_in     = CW'(dc1);
            bc_in     = bc_ff + nb_ff;
            from_in   = cur;
            to_in     = ins;
            nbase_in  = addr_ff;
            nblk_in   = nb_ff;
            ndisp_in  = flag_ff;
            active_in = ins;
            state_in  = lmct_pkg::ST_MOVE;
         end
         lmct_pkg::ST_MOVE: begin
            state_in = lmct_pkg::ST_REPLY;
         end
         lmct_pkg::ST_REPLY: begin
            state_in = lmct_pkg::ST_IDLE;
         end
         default: begin
            state_in = lmct_pkg::ST_IDLE;
         end
      endcase
   end

   logic [31:0] act_ext, evc_ext, evt_ext, evb_ext, mc_ext, bc_ext;
   assign act_ext = 32'(active_ff);
   assign evc_ext = 32'(evc_ff);
   assign evt_ext = 32'(evt_ff);
   assign evb_ext = 32'(evb_ff);
   assign mc_ext  = 32'(mc_ff);
   assign bc_ext  = 32'(bc_ff);

   assign busy       = (state_ff != lmct_pkg::ST_IDLE);
   assign rsp_strobe = (state_ff == lmct_pkg::ST_REPLY);
   assign rsp_data.status              = status_ff;
   assign rsp_data.active_slot         = act_ext[3:0];
   assign rsp_data.evicted_by_capacity = evc_ext[4:0];
   assign rsp_data.evicted_by_tag      = evt_ext[4:0];
   assign rsp_data.released_blocks     = evb_ext[4:0];
   assign rsp_data.resident_methods    = mc_ext[4:0];
   assign rsp_data.resident_blocks     = bc_ext[4:0];

   a_disp_le_methods: assert property (@(posedge clock) disable iff (reset)
      dc_ff <= mc_ff) else $error("disposable count exceeds method count");
   a_blocks_bounded: assert property (@(posedge clock) disable iff (reset)
      XW'(bc_ff) <= NX) else $error("block count exceeds table");
   a_reply_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy) else $error("result not followed by idle");
   a_methods_bounded: assert property (@(posedge clock) disable iff (reset)
      XW'(mc_ff) <= NX) else $error("method count exceeds table");

endmodule

### sv/lmct_cell.sv
// One table slot: base, block count, disposable mark; shifted from the upper neighbor or loaded new.
// Depends on lmct_pkg.
module lmct_cell #(
   parameter int ADDR_WIDTH = 32,
   parameter int BW = 5
) (
   input  logic                      clock,
   input  lmct_pkg::cell_ctrl_type   ctrl,
   input  logic [ADDR_WIDTH-1:0]     up_base,
   input  logic [BW-1:0]             up_blocks,
   input  logic                      up_disp,
   input  logic [ADDR_WIDTH-1:0]     new_base,
   input  logic [BW-1:0]             new_blocks,
   input  logic                      new_disp,
   input  logic [ADDR_WIDTH-1:0]     cmp_addr,
   output logic [ADDR_WIDTH-1:0]     base,
   output logic [BW-1:0]             blocks,
   output logic                      disp,
   output logic                      match
);

   logic [ADDR_WIDTH-1:0] base_ff;
   logic [BW-1:0]         blocks_ff;
   logic                  disp_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load_new) begin
         base_ff   <= new_base;
         blocks_ff <= new_blocks;
         disp_ff   <= new_disp;
      end else if (ctrl.take_upper) begin
         base_ff   <= up_base;
         blocks_ff <= up_blocks;
         disp_ff   <= up_disp;
      end
   end

   assign base   = base_ff;
   assign blocks = blocks_ff;
   assign disp   = disp_ff;
   assign match  = (base_ff == cmp_addr);

endmodule
